/* sv/cbl_pkg.sv */
`default_nettype none
package cbl_pkg;

  localparam int unsigned BlockSlotsDefault = 32;
  localparam int unsigned IdxW = 5;
  localparam int unsigned FifoDepth = 2;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0]     word;
    logic [IdxW-1:0] idx;
    logic            first;
    logic            last;
  } cbl_entry_t;

  // reflected CRC-32 over four little-endian bytes, raw register form
  function automatic logic [31:0] crc32_word(input logic [31:0] c_in, input logic [31:0] w);
    logic [31:0] c;
    logic        fb;
    c = c_in;
    for (int i = 0; i < 32; i++) begin
      fb = c[0] ^ w[i];
      c  = {1'b0, c[31:1]} ^ (fb ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/cbl_front.sv */
`default_nettype none
module cbl_front #(
  parameter int unsigned BLOCK_SLOTS = cbl_pkg::BlockSlotsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic signed [31:0] transaction_i,
  output logic                    push_o,
  output cbl_pkg::cbl_entry_t     entry_o,
  input  wire logic               full_i
);
  import cbl_pkg::*;

  localparam int unsigned SlotW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(BLOCK_SLOTS - 1);

  logic [SlotW-1:0] slot_q, slot_d;
  logic             last;

  assign ready_o = !full_i;
  assign push_o  = valid_i && ready_o;
  assign last    = (slot_q == SlotLast);

  always_comb begin
    entry_o.word  = transaction_i;
    entry_o.idx   = IdxW'(slot_q);
    entry_o.first = (slot_q == '0);
    entry_o.last  = last;
  end

  always_comb begin
    slot_d = slot_q;
    if (push_o) begin
      slot_d = last ? '0 : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule
`default_nettype wire

/* sv/cbl_fifo.sv */
`default_nettype none
module cbl_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire cbl_pkg::cbl_entry_t  entry_i,
  output logic                      full_o,
  output logic                      valid_o,
  input  wire logic                 pop_i,
  output cbl_pkg::cbl_entry_t       entry_o
);
  import cbl_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  cbl_entry_t      mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* sv/cbl_back.sv */
`default_nettype none
module cbl_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          pop_o,
  input  wire cbl_pkg::cbl_entry_t      entry_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [cbl_pkg::IdxW-1:0]      slot_index_o,
  output logic                          block_closed_o,
  output logic [31:0]                   block_checksum_o
);
  import cbl_pkg::*;

  logic [31:0]     crc_q, crc_d, link_q, link_d;
  logic [31:0]     base, nxt;
  logic            ov_q, ov_d;
  logic [IdxW-1:0] idx_q;
  logic            closed_q;
  logic [31:0]     sum_q;

  assign pop_o = valid_i && (!ov_q || out_ready_i);

  // block start folds the link in ahead of the word
  assign base = entry_i.first ? crc32_word(CrcInit, link_q) : crc_q;
  assign nxt  = crc32_word(base, entry_i.word);

  always_comb begin
    crc_d  = crc_q;
    link_d = link_q;
    ov_d   = ov_q;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (pop_o) begin
      ov_d = 1'b1;
      if (entry_i.last) begin
        link_d = ~nxt;
        crc_d  = CrcInit;
      end else begin
        crc_d = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcInit;
      link_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      link_q <= link_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      idx_q    <= entry_i.idx;
      closed_q <= entry_i.last;
      sum_q    <= entry_i.last ? ~nxt : 32'h0;
    end
  end

  assign out_valid_o      = ov_q;
  assign slot_index_o     = idx_q;
  assign block_closed_o   = closed_q;
  assign block_checksum_o = sum_q;

endmodule
`default_nettype wire

/* sv/crc32_chained_block_log.sv */
// Chained CRC-32 block log.
// Path: an accepted word is written into the queue, then the CRC stage registers its result.
// Throughput: one word per cycle while out_ready_i is held high; the CRC stage folds 32 bits, 64 at block start.
// A two-entry queue separates the slot counter from the CRC stage.
// Reset (async, active low): empty queue, slot 0, link 0, no result pending.
`default_nettype none
module crc32_chained_block_log #(
  parameter int unsigned BLOCK_SLOTS = cbl_pkg::BlockSlotsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic signed [31:0]   transaction_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [cbl_pkg::IdxW-1:0]  slot_index_o,
  output logic                      block_closed_o,
  output logic [31:0]               block_checksum_o
);
  import cbl_pkg::*;

  cbl_entry_t push_entry, pop_entry;
  logic       push, full, q_valid, pop;

  cbl_front #(
    .BLOCK_SLOTS(BLOCK_SLOTS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .valid_i,
    .ready_o,
    .transaction_i,
    .push_o  (push),
    .entry_o (push_entry),
    .full_i  (full)
  );

  cbl_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (pop_entry)
  );

  cbl_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (q_valid),
    .pop_o   (pop),
    .entry_i (pop_entry),
    .out_valid_o,
    .out_ready_i,
    .slot_index_o,
    .block_closed_o,
    .block_checksum_o
  );

endmodule
`default_nettype wire
